[sv/assert_macros.svh]
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

[sv/sat_pkg.sv]
`timescale 1ns / 1ps
package sat_pkg;

  localparam int DEPTH_DEF    = 32;
  localparam int VW_DEF       = 32;
  localparam int RESULT_LIMIT = 32;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_SORT    = 3'd2,
    OP_SIDX    = 3'd3,
    OP_SETSORT = 3'd4,
    OP_CLEAR   = 3'd5,
    OP_READ    = 3'd6,
    OP_NONE    = 3'd7
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] value;
    logic               at_front;
    logic [4:0]         position;
    logic               sorted_mode;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] data;
    logic [4:0]         order_index;
    logic [5:0]         count;
    logic               is_sorted;
    logic               last;
  } out_t;

endpackage

[sv/sortable_array_table.sv]
`timescale 1ns / 1ps
// Bounded table of signed values with a sorted-mode flag, one operation per input transfer,
// one operation at a time. Entries live in a RAM with a registered read; a second RAM holds
// (index, value) pairs for the sorted-index permutation. Sorted or front insert and sorted
// remove shift the entries one by one; sort is a selection sort whose scan reads one entry
// per cycle through the single read port of the RAM that it sorts (the entry RAM, or the
// pair RAM for sorted index); sorted index copies the entries into the pair RAM before the
// sort and emits one result per entry after it, up to RESULT_LIMIT. A stalled output holds
// the sequencer.
module sortable_array_table #(
  parameter int DEPTH       = sat_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = sat_pkg::VW_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sat_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sat_pkg::out_t out_data_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = VALUE_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_INS_RD, S_INS_CMP, S_REM_RD, S_REM_WR, S_RD_W,
    S_SRT_I, S_SRT_IW, S_SRT_J, S_SRT_SW1, S_SRT_SW2,
    S_CPY, S_CPY_W, S_EM_RD, S_EM_OUT
  } state_e;
  localparam state_e S_FIN = S_IDLE;

  state_e          state_q, state_d;
  logic            fin_q, fin_d;
  sat_pkg::op_e    op_q, op_d;
  logic [VW-1:0]   val_q, val_d;
  logic            front_q, front_d;
  logic [4:0]      pos_q, pos_d;
  logic            mode_q, mode_d;
  logic [CW-1:0]   count_q, count_d;
  logic            sorted_q, sorted_d;
  logic [AW-1:0]   i_q, i_d, j_q, j_d, k_q, k_d;
  logic            tscr_q, tscr_d;
  logic [VW-1:0]   cur_v_q, cur_v_d, min_v_q, min_v_d;
  logic [AW-1:0]   cur_x_q, cur_x_d, min_x_q, min_x_d;
  logic            ok_q, ok_d;
  logic [31:0]     data_q, data_d;
  logic            out_valid_q, out_valid_d;
  sat_pkg::out_t   out_q, out_d;

  logic            e_we, e_re, s_we, s_re;
  logic [AW-1:0]   e_waddr, e_raddr, s_waddr, s_raddr;
  logic [VW-1:0]   e_wdata, e_rdata;
  logic [AW+VW-1:0] s_wdata, s_rdata;

  logic [VW-1:0]   rd_v;
  logic [AW-1:0]   rd_x;
  logic [63:0]     vin64, rd64;
  logic [31:0]     posw, n32, i32, j32, emit32, cnt32, x32;
  logic [AW-1:0]   pos_a, cnt_a;
  logic            pos_bad, out_free;

  sat_ram #(.DEPTH(DEPTH), .WIDTH(VW)) u_elem (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .re_i(e_re), .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  sat_ram #(.DEPTH(DEPTH), .WIDTH(AW + VW)) u_scr (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .re_i(s_re), .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  always_comb begin
    vin64    = 64'(in_data_i.value);
    rd_v     = tscr_q ? s_rdata[VW-1:0] : e_rdata;
    rd_x     = s_rdata[AW+VW-1:VW];
    rd64     = 64'($signed(rd_v));
    posw     = 32'(pos_q);
    pos_a    = posw[AW-1:0];
    n32      = 32'(count_q);
    cnt_a    = n32[AW-1:0];
    i32      = 32'(i_q);
    j32      = 32'(j_q);
    x32      = 32'(rd_x);
    emit32   = (n32 < sat_pkg::RESULT_LIMIT) ? n32 : sat_pkg::RESULT_LIMIT;
    pos_bad  = (posw >= n32) || (posw >= DEPTH);
    out_free = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    state_d = state_q;   fin_d = fin_q;
    op_d = op_q;         val_d = val_q;     front_d = front_q;
    pos_d = pos_q;       mode_d = mode_q;
    count_d = count_q;   sorted_d = sorted_q;
    i_d = i_q;           j_d = j_q;         k_d = k_q;
    tscr_d = tscr_q;
    cur_v_d = cur_v_q;   cur_x_d = cur_x_q;
    min_v_d = min_v_q;   min_x_d = min_x_q;
    ok_d = ok_q;         data_d = data_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;
    e_we = 1'b0; e_waddr = i_q; e_wdata = val_q; e_re = 1'b0; e_raddr = i_q;
    s_we = 1'b0; s_waddr = i_q; s_wdata = {cur_x_q, cur_v_q}; s_re = 1'b0; s_raddr = i_q;
    cnt32 = n32;

    case (state_q)
      S_IDLE: begin
        if (fin_q) begin
          if (out_free) begin
            cnt32 = n32;
            out_valid_d       = 1'b1;
            out_d.ok          = ok_q;
            out_d.data        = data_q;
            out_d.order_index = '0;
            out_d.count       = cnt32[5:0];
            out_d.is_sorted   = sorted_q;
            out_d.last        = 1'b1;
            fin_d             = 1'b0;
          end
        end else if (in_valid_i) begin
          op_d    = in_data_i.operation;
          val_d   = vin64[VW-1:0];
          front_d = in_data_i.at_front;
          pos_d   = in_data_i.position;
          mode_d  = in_data_i.sorted_mode;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        ok_d    = 1'b1;
        data_d  = '0;
        state_d = S_FIN;
        fin_d   = 1'b1;
        case (op_q)
          sat_pkg::OP_INSERT: begin
            if (n32 >= DEPTH) begin
              ok_d = 1'b0;
            end else if (sorted_q || front_q) begin
              i_d     = cnt_a;
              fin_d   = 1'b0;
              state_d = S_INS_RD;
            end else begin
              e_we    = 1'b1;
              e_waddr = cnt_a;
              count_d = count_q + CW'(1);
            end
          end
          sat_pkg::OP_REMOVE: begin
            if (pos_bad) begin
              ok_d = 1'b0;
            end else if (sorted_q) begin
              j_d     = pos_a;
              fin_d   = 1'b0;
              state_d = S_REM_RD;
            end else if (posw + 32'd1 != n32) begin
              e_re    = 1'b1;
              e_raddr = AW'(n32 - 32'd1);
              j_d     = pos_a;
              fin_d   = 1'b0;
              state_d = S_REM_WR;
            end else begin
              count_d = count_q - CW'(1);
            end
          end
          sat_pkg::OP_SORT: begin
            sorted_d = 1'b1;
            tscr_d   = 1'b0;
            i_d      = '0;
            fin_d    = 1'b0;
            state_d  = S_SRT_I;
          end
          sat_pkg::OP_SIDX: begin
            if (n32 == 32'd0) begin
              ok_d = 1'b0;
            end else begin
              i_d     = '0;
              fin_d   = 1'b0;
              state_d = S_CPY;
            end
          end
          sat_pkg::OP_SETSORT: sorted_d = mode_q;
          sat_pkg::OP_CLEAR: begin
            count_d  = '0;
            sorted_d = 1'b0;
          end
          sat_pkg::OP_READ: begin
            if (pos_bad) begin
              ok_d = 1'b0;
            end else begin
              e_re    = 1'b1;
              e_raddr = pos_a;
              tscr_d  = 1'b0;
              fin_d   = 1'b0;
              state_d = S_RD_W;
            end
          end
          default: ok_d = 1'b0;
        endcase
      end
      S_RD_W: begin
        data_d  = rd64[31:0];
        fin_d   = 1'b1;
        state_d = S_FIN;
      end
      S_INS_RD: begin
        if (i32 == 32'd0) begin
          e_we    = 1'b1;
          e_waddr = '0;
          count_d = count_q + CW'(1);
          fin_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          e_re    = 1'b1;
          e_raddr = i_q - AW'(1);
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        e_we    = 1'b1;
        e_waddr = i_q;
        if (!sorted_q || ($signed(val_q) < $signed(e_rdata))) begin
          e_wdata = e_rdata;
          i_d     = i_q - AW'(1);
          state_d = S_INS_RD;
        end else begin
          count_d = count_q + CW'(1);
          fin_d   = 1'b1;
          state_d = S_FIN;
        end
      end
      S_REM_RD: begin
        if (j32 + 32'd1 < n32) begin
          e_re    = 1'b1;
          e_raddr = j_q + AW'(1);
          state_d = S_REM_WR;
        end else begin
          count_d = count_q - CW'(1);
          fin_d   = 1'b1;
          state_d = S_FIN;
        end
      end
      S_REM_WR: begin
        e_we    = 1'b1;
        e_waddr = j_q;
        e_wdata = e_rdata;
        if (sorted_q) begin
          j_d     = j_q + AW'(1);
          state_d = S_REM_RD;
        end else begin
          count_d = count_q - CW'(1);
          fin_d   = 1'b1;
          state_d = S_FIN;
        end
      end
      S_CPY: begin
        if (i32 < n32) begin
          e_re    = 1'b1;
          e_raddr = i_q;
          state_d = S_CPY_W;
        end else begin
          i_d     = '0;
          tscr_d  = 1'b1;
          state_d = S_SRT_I;
        end
      end
      S_CPY_W: begin
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = {i_q, e_rdata};
        if (i32 + 32'd1 < n32) begin
          i_d     = i_q + AW'(1);
          state_d = S_CPY;
        end else begin
          i_d     = '0;
          tscr_d  = 1'b1;
          state_d = S_SRT_I;
        end
      end
      S_SRT_I: begin
        if (i32 + 32'd1 >= n32) begin
          if (tscr_q) begin
            i_d     = '0;
            state_d = S_EM_RD;
          end else begin
            fin_d   = 1'b1;
            state_d = S_FIN;
          end
        end else begin
          e_re    = !tscr_q;
          s_re    = tscr_q;
          e_raddr = i_q;
          s_raddr = i_q;
          state_d = S_SRT_IW;
        end
      end
      S_SRT_IW: begin
        cur_v_d = rd_v;
        cur_x_d = rd_x;
        min_v_d = rd_v;
        min_x_d = rd_x;
        k_d     = i_q;
        j_d     = i_q + AW'(1);
        e_re    = !tscr_q;
        s_re    = tscr_q;
        e_raddr = i_q + AW'(1);
        s_raddr = i_q + AW'(1);
        state_d = S_SRT_J;
      end
      S_SRT_J: begin
        if ($signed(rd_v) < $signed(min_v_q)) begin
          min_v_d = rd_v;
          min_x_d = rd_x;
          k_d     = j_q;
        end
        if (j32 + 32'd1 < n32) begin
          j_d     = j_q + AW'(1);
          e_re    = !tscr_q;
          s_re    = tscr_q;
          e_raddr = j_q + AW'(1);
          s_raddr = j_q + AW'(1);
        end else begin
          state_d = S_SRT_SW1;
        end
      end
      S_SRT_SW1: begin
        e_we    = !tscr_q;
        s_we    = tscr_q;
        e_waddr = i_q;
        s_waddr = i_q;
        e_wdata = min_v_q;
        s_wdata = {min_x_q, min_v_q};
        state_d = S_SRT_SW2;
      end
      S_SRT_SW2: begin
        e_we    = !tscr_q;
        s_we    = tscr_q;
        e_waddr = k_q;
        s_waddr = k_q;
        e_wdata = cur_v_q;
        s_wdata = {cur_x_q, cur_v_q};
        i_d     = i_q + AW'(1);
        state_d = S_SRT_I;
      end
      S_EM_RD: begin
        s_re    = 1'b1;
        s_raddr = i_q;
        state_d = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.ok          = 1'b1;
          out_d.data        = rd64[31:0];
          out_d.order_index = x32[4:0];
          out_d.count       = cnt32[5:0];
          out_d.is_sorted   = sorted_q;
          out_d.last        = (i32 + 32'd1 == emit32);
          i_d               = i_q + AW'(1);
          state_d           = (i32 + 32'd1 == emit32) ? S_IDLE : S_EM_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fin_q       <= 1'b0;
      count_q     <= '0;
      sorted_q    <= 1'b0;
      out_valid_q <= 1'b0;
      tscr_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      fin_q       <= fin_d;
      count_q     <= count_d;
      sorted_q    <= sorted_d;
      out_valid_q <= out_valid_d;
      tscr_q      <= tscr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;    val_q   <= val_d;   front_q <= front_d;
    pos_q   <= pos_d;   mode_q  <= mode_d;
    i_q     <= i_d;     j_q     <= j_d;     k_q     <= k_d;
    cur_v_q <= cur_v_d; cur_x_q <= cur_x_d;
    min_v_q <= min_v_d; min_x_q <= min_x_d;
    ok_q    <= ok_d;    data_q  <= data_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE) || fin_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_bound, 32'(count_q) <= DEPTH, "count exceeds depth")
  `ASSERT_NEXT(a_accept_disp, in_valid_i && !in_stall_o, state_q == S_DISP, "transfer not dispatched")
  `ASSERT_NEXT(a_out_hold, out_valid_q && out_stall_i, out_valid_q && $stable(out_q), "result lost under stall")
  `ASSERT_NEXT(a_fin_push, fin_q && state_q == S_IDLE && out_free, out_valid_q && out_q.last, "final result missing")

endmodule

[sv/sat_ram.sv]
`timescale 1ns / 1ps
module sat_ram #(
  parameter int DEPTH = sat_pkg::DEPTH_DEF,
  parameter int WIDTH = sat_pkg::VW_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[test/tb_sortable_array_table.sv]
`timescale 1ns / 1ps
module tb_sortable_array_table;

  localparam int SLOTS      = 32;
  localparam int RAND_ITEMS = 370;
  localparam int STALL_CAP  = 40000;

  class table_tracker;
    logic signed [31:0] vals[SLOTS];
    int unsigned        fill;
    bit                 ordered;
    sat_pkg::out_t      pending[$];
    int                 errors;

    function void post(bit ok, logic signed [31:0] d, int oi, bit fin);
      sat_pkg::out_t r;
      r.ok          = ok;
      r.data        = d;
      r.order_index = oi[4:0];
      r.count       = fill[5:0];
      r.is_sorted   = ordered;
      r.last        = fin;
      pending.push_back(r);
    endfunction

    function void take_op(sat_pkg::in_t it);
      int                 i;
      int                 j;
      int                 k;
      int                 t;
      int                 perm[SLOTS];
      logic signed [31:0] tmp;
      case (it.operation)
        sat_pkg::OP_INSERT: begin
          if (fill >= SLOTS) begin
            post(0, 0, 0, 1);
          end else begin
            if (ordered) begin
              i = fill;
              while (i > 0 && it.value < vals[i-1]) begin
                vals[i] = vals[i-1];
                i--;
              end
              vals[i] = it.value;
            end else if (it.at_front) begin
              for (i = fill; i > 0; i--) vals[i] = vals[i-1];
              vals[0] = it.value;
            end else begin
              vals[fill] = it.value;
            end
            fill++;
            post(1, 0, 0, 1);
          end
        end
        sat_pkg::OP_REMOVE: begin
          if (it.position >= fill) begin
            post(0, 0, 0, 1);
          end else begin
            fill--;
            if (ordered) begin
              for (j = it.position; j < fill; j++) vals[j] = vals[j+1];
            end else if (it.position != fill) begin
              vals[it.position] = vals[fill];
            end
            post(1, 0, 0, 1);
          end
        end
        sat_pkg::OP_SORT: begin
          ordered = 1;
          for (i = 0; i + 1 < fill; i++) begin
            k = i;
            for (j = i + 1; j < fill; j++) if (vals[j] < vals[k]) k = j;
            tmp = vals[i];
            vals[i] = vals[k];
            vals[k] = tmp;
          end
          post(1, 0, 0, 1);
        end
        sat_pkg::OP_SIDX: begin
          if (fill == 0) begin
            post(0, 0, 0, 1);
          end else begin
            for (i = 0; i < fill; i++) perm[i] = i;
            for (i = 0; i + 1 < fill; i++) begin
              k = i;
              for (j = i + 1; j < fill; j++) if (vals[perm[j]] < vals[perm[k]]) k = j;
              t = perm[i];
              perm[i] = perm[k];
              perm[k] = t;
            end
            for (i = 0; i < fill; i++) post(1, vals[perm[i]], perm[i], i + 1 == fill);
          end
        end
        sat_pkg::OP_SETSORT: begin
          ordered = it.sorted_mode;
          post(1, 0, 0, 1);
        end
        sat_pkg::OP_CLEAR: begin
          fill    = 0;
          ordered = 0;
          post(1, 0, 0, 1);
        end
        sat_pkg::OP_READ: begin
          if (it.position >= fill) post(0, 0, 0, 1);
          else post(1, vals[it.position], 0, 1);
        end
        default: post(0, 0, 0, 1);
      endcase
    endfunction

    function void field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void match_result(sat_pkg::out_t got);
      sat_pkg::out_t want;
      if (pending.size() == 0) begin
        $error("result with nothing pending: %p", got);
        errors++;
      end else begin
        want = pending.pop_front();
        field("ok", want.ok, got.ok);
        field("data", want.data, got.data);
        field("order_index", want.order_index, got.order_index);
        field("count", want.count, got.count);
        field("is_sorted", want.is_sorted, got.is_sorted);
        field("last", want.last, got.last);
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  sat_pkg::in_t   in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  sat_pkg::out_t  out_data_o;

  table_tracker tracker;
  int            gap_pct;
  int            stall_pct;
  int            idle_cycles;
  int            sent;

  sortable_array_table uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.match_result(out_data_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= STALL_CAP) begin
        $display("tb_sortable_array_table: errors");
        $finish;
      end
    end
  end

  task automatic push_op(sat_pkg::op_e op, logic signed [31:0] v = 0, bit front = 0,
                         logic [4:0] pos = 0, bit mode = 0);
    sat_pkg::in_t it;
    it.operation   = op;
    it.value       = v;
    it.at_front    = front;
    it.position    = pos;
    it.sorted_mode = mode;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i = 0;
      @(negedge clk_i);
    end
    in_valid_i = 1;
    in_data_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_op(it);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic random_op();
    int                 r;
    logic signed [31:0] v;
    logic [4:0]         pos;
    r   = $urandom_range(99);
    v   = ($urandom_range(3) == 0) ? $signed($urandom_range(7)) - 4 : $urandom;
    pos = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(tracker.fill);
    if (r < 40) push_op(sat_pkg::OP_INSERT, v, $urandom_range(1));
    else if (r < 52) push_op(sat_pkg::OP_REMOVE, 0, 0, pos);
    else if (r < 67) push_op(sat_pkg::OP_READ, $urandom, $urandom_range(1), pos);
    else if (r < 72) push_op(sat_pkg::OP_SORT);
    else if (r < 78) push_op(sat_pkg::OP_SIDX);
    else if (r < 86) push_op(sat_pkg::OP_SETSORT, 0, 0, 0, $urandom_range(1));
    else if (r < 88) push_op(sat_pkg::OP_CLEAR);
    else if (r < 90) push_op(sat_pkg::OP_NONE, $urandom, $urandom_range(1), $urandom, 1);
    else begin
      repeat ($urandom_range(34, 20)) push_op(sat_pkg::OP_INSERT, $urandom, $urandom_range(1));
      push_op($urandom_range(1) ? sat_pkg::OP_SIDX : sat_pkg::OP_SORT);
    end
  endtask

  initial begin
    int n;
    tracker     = new();
    gap_pct     = 0;
    stall_pct   = 0;
    idle_cycles = 0;
    sent        = 0;
    rst_ni      = 0;
    in_valid_i  = 0;
    in_data_i   = '0;
    out_stall_i = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1;

    push_op(sat_pkg::OP_READ, 0, 0, 0);
    push_op(sat_pkg::OP_REMOVE, 0, 0, 31);
    push_op(sat_pkg::OP_SIDX);
    push_op(sat_pkg::OP_NONE, -1, 1, 31, 1);
    push_op(sat_pkg::OP_INSERT, 32'sh7fffffff, 0);
    push_op(sat_pkg::OP_INSERT, 32'sh80000000, 1);
    push_op(sat_pkg::OP_INSERT, 0, 0);
    push_op(sat_pkg::OP_INSERT, -1, 1);
    push_op(sat_pkg::OP_READ, 0, 0, 3);
    push_op(sat_pkg::OP_READ, 0, 0, 4);
    push_op(sat_pkg::OP_SIDX);
    push_op(sat_pkg::OP_REMOVE, 0, 0, 1);
    push_op(sat_pkg::OP_SORT);
    push_op(sat_pkg::OP_INSERT, 5, 0);
    push_op(sat_pkg::OP_INSERT, -1, 1);
    push_op(sat_pkg::OP_REMOVE, 0, 0, 0);
    push_op(sat_pkg::OP_READ, 0, 0, 2);
    push_op(sat_pkg::OP_SETSORT, 0, 0, 0, 0);
    push_op(sat_pkg::OP_SETSORT, 0, 0, 0, 1);
    push_op(sat_pkg::OP_CLEAR);
    push_op(sat_pkg::OP_SORT);

    while (sent < RAND_ITEMS) begin
      case (sent * 4 / RAND_ITEMS)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 74; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 74; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      random_op();
    end
    in_valid_i = 0;

    n = 0;
    while (tracker.pending.size() != 0 && n < STALL_CAP) begin
      @(posedge clk_i);
      n++;
    end
    repeat (200) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("tb_sortable_array_table: clean");
    end else begin
      $display("tb_sortable_array_table: errors");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+sv
sv/sat_pkg.sv
sv/sat_ram.sv
sv/sortable_array_table.sv
test/tb_sortable_array_table.sv
